[rtl/x86alu_pkg.sv]
// Package with operation codes, states and helper functions for the ALU unit.
`timescale 1ns / 1ps
`default_nettype none
package x86alu_pkg;
    localparam int DataWidth = 16;
    localparam int StepCount = 16;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_CMP = 5'd2, OP_INC = 5'd3, OP_DEC = 5'd4,
        OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_NOT = 5'd8, OP_NEG = 5'd9,
        OP_SHL = 5'd10, OP_SHR = 5'd11, OP_MUL = 5'd12, OP_IMUL = 5'd13,
        OP_DIV = 5'd14, OP_IDIV = 5'd15, OP_JMP = 5'd16, OP_JE = 5'd17,
        OP_JNE = 5'd18, OP_JG = 5'd19, OP_JGE = 5'd20, OP_JL = 5'd21, OP_JLE = 5'd22
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0, FAULT_ZERO = 2'd1, FAULT_RANGE = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ITER, ST_FIX, ST_DONE
    } state_t;

    typedef struct packed {
        logic pf;
        logic af;
        logic of;
        logic sf;
        logic zf;
        logic cf;
    } flags_t;

    typedef struct packed {
        logic start;
        logic is_div;
        logic busy;
        logic done;
    } iter_ctl_t;

    function automatic logic parity_even(input logic [7:0] v);
        return ~(^v);
    endfunction
endpackage
`default_nettype wire

[rtl/x86alu_iter.sv]
// Shared shift-add multiplier and restoring divider on unsigned magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module x86alu_iter
    import x86alu_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire iter_ctl_t                 ctl_in,
    input  wire logic [2*DataWidth-1:0]    op_a,
    input  wire logic [DataWidth-1:0]      op_b,
    output iter_ctl_t                      ctl_out,
    output logic [2*DataWidth-1:0]         acc,
    output logic [DataWidth:0]             rem
);
    localparam int CntW = $clog2(StepCount + 1);
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic [2*DataWidth-1:0]   acc_reg, acc_next;
    logic [DataWidth:0]       rem_reg, rem_next;
    logic [DataWidth-1:0]     b_reg, b_next;
    logic                     div_reg, div_next;
    logic [DataWidth+1:0]     trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
        div_reg <= div_next;
    end

    always_comb begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        b_next   = b_reg;
        div_next = div_reg;
        trial    = '0;
        if (ctl_in.start) begin
            cnt_next = CntW'(StepCount);
            acc_next = ctl_in.is_div ? op_a : {{DataWidth{1'b0}}, op_a[DataWidth-1:0]};
            rem_next = ctl_in.is_div ? {1'b0, op_a[2*DataWidth-1:DataWidth]} : '0;
            b_next   = op_b;
            div_next = ctl_in.is_div;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (div_reg) begin
                trial = {rem_reg, acc_reg[DataWidth-1]} - {2'b00, b_reg};
                if (!trial[DataWidth+1]) begin
                    rem_next = trial[DataWidth:0];
                    acc_next = {acc_reg[2*DataWidth-1:DataWidth],
                                acc_reg[DataWidth-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[DataWidth-1:0], acc_reg[DataWidth-1]};
                    acc_next = {acc_reg[2*DataWidth-1:DataWidth],
                                acc_reg[DataWidth-2:0], 1'b0};
                end
            end else begin
                trial = {2'b00, acc_reg[2*DataWidth-1:DataWidth]}
                      + (acc_reg[0] ? {2'b00, b_reg} : '0);
                acc_next = {trial[DataWidth:0], acc_reg[DataWidth-1:1]};
            end
        end
    end

    assign acc = acc_reg;
    assign rem = rem_reg;
    always_comb begin
        ctl_out        = '0;
        ctl_out.is_div = div_reg;
        ctl_out.busy   = cnt_reg != '0;
        ctl_out.done   = cnt_reg == CntW'(1);
    end

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_in.start |=> cnt_reg == CntW'(StepCount)) else $error("count not loaded");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && !ctl_in.start) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("count did not step");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_reg && cnt_reg == '0 && !ctl_in.start && $past(cnt_reg) == CntW'(1)
         && acc_reg[2*DataWidth-1:DataWidth] < b_reg)
        |-> rem_reg < {1'b0, b_reg}) else $error("remainder not below divisor");
endmodule
`default_nettype wire

[rtl/x86_16bit_alu_with_flags_unit.sv]
// Top level of the 16-bit ALU unit with its flag register and sequencer.
//
// Channel  Direction  tdata fields (low bit up)                        tuser
// s_axis   in         kind[4:0] dest[20:5] src[36:21] high[52:37]      none
// m_axis   out        see m_tdata port comment                         none
//
// Simple operations go from accept through the fix-up state to the result; MUL, IMUL, DIV
// and IDIV first load and run the 16 steps of the shared multiply/divide unit, then fix up.
// Reset clears the flags to zero and returns the sequencer to idle.
// s_tready is low while an item is in work or its result waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none
module x86_16bit_alu_with_flags_unit
    import x86alu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // kind, dest_value, src_value, high_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0] m_tdata  // result_low, result_high, write_low, write_high,
                                 // branch_taken, fault, carry, zero, sign, overflow,
                                 // aux, parity
);
    localparam int W = DataWidth;
    state_t state_reg, state_next;
    flags_t flags_reg, flags_next;
    op_t    op_reg, op_next;
    logic [W-1:0] d_reg, d_next, s_reg, s_next, h_reg, h_next;
    logic [W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic wl_reg, wl_next, wh_reg, wh_next, br_reg, br_next;
    fault_t fault_reg, fault_next;
    logic nneg_reg, nneg_next, sneg_reg, sneg_next;

    iter_ctl_t ictl, istat;
    logic [2*W-1:0] ia, iacc;
    logic [W-1:0] ib;
    logic [W:0] irem;

    x86alu_iter u_iter (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(ictl), .op_a(ia), .op_b(ib),
        .ctl_out(istat), .acc(iacc), .rem(irem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flags_reg <= '0;
        end else begin
            state_reg <= state_next;
            flags_reg <= flags_next;
        end
        op_reg <= op_next; d_reg <= d_next; s_reg <= s_next; h_reg <= h_next;
        lo_reg <= lo_next; hi_reg <= hi_next; wl_reg <= wl_next; wh_reg <= wh_next;
        br_reg <= br_next; fault_reg <= fault_next;
        nneg_reg <= nneg_next; sneg_reg <= sneg_next;
    end

    logic [W:0] sum;
    logic [W-1:0] r, ad, as_, qm, rm;
    logic [2*W-1:0] nmag, prod;
    logic sub_op, ov, qneg;

    // The iteration keeps the high dividend word in the upper accumulator half.
    function automatic logic [W-1:0] ib_mag(input logic [W-1:0] v, input logic neg);
        return neg ? -v : v;
    endfunction

    always_comb begin
        state_next = state_reg; flags_next = flags_reg;
        op_next = op_reg; d_next = d_reg; s_next = s_reg; h_next = h_reg;
        lo_next = lo_reg; hi_next = hi_reg; wl_next = wl_reg; wh_next = wh_reg;
        br_next = br_reg; fault_next = fault_reg;
        nneg_next = nneg_reg; sneg_next = sneg_reg;
        ictl = '0; ia = '0; ib = '0;
        sum = '0; r = '0; ad = '0; as_ = '0; sub_op = 1'b0;
        nmag = '0; prod = '0; ov = 1'b0; qneg = 1'b0; qm = '0; rm = '0;
        s_tready = state_reg == ST_IDLE;
        m_tvalid = state_reg == ST_DONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next = op_t'(s_tdata[4:0]);
                    d_next = s_tdata[20:5]; s_next = s_tdata[36:21];
                    h_next = s_tdata[52:37];
                    state_next = ST_FIX;
                    if (s_tdata[4:0] >= OP_MUL && s_tdata[4:0] <= OP_IDIV) begin
                        state_next = ST_ITER;
                        ictl.start = 1'b1;
                        ictl.is_div = s_tdata[4:0] >= OP_DIV;
                        nneg_next = s_tdata[4:0] != OP_MUL && s_tdata[4:0] != OP_DIV
                                    && (s_tdata[4:0] == OP_IMUL ? s_tdata[20] : s_tdata[52]);
                        sneg_next = s_tdata[4:0] != OP_MUL && s_tdata[4:0] != OP_DIV
                                    && s_tdata[36];
                        nmag = {s_tdata[52:37], s_tdata[20:5]};
                        if (s_tdata[4:0] == OP_IMUL) begin
                            ia = {{W{1'b0}}, s_tdata[20] ? -s_tdata[20:5] : s_tdata[20:5]};
                        end else if (s_tdata[4:0] == OP_IDIV && s_tdata[52]) begin
                            ia = -nmag;
                        end else if (s_tdata[4:0] == OP_MUL) begin
                            ia = {{W{1'b0}}, s_tdata[20:5]};
                        end else begin
                            ia = nmag;
                        end
                        ib = (s_tdata[4:0] != OP_MUL && s_tdata[4:0] != OP_DIV
                              && s_tdata[36]) ? -s_tdata[36:21] : s_tdata[36:21];
                    end
                end
            end
            ST_ITER: begin
                if (istat.done) state_next = ST_FIX;
            end
            ST_FIX: begin
                state_next = ST_DONE;
                lo_next = '0; hi_next = '0; wl_next = 1'b0; wh_next = 1'b0;
                br_next = 1'b0; fault_next = FAULT_NONE;
                ad = d_reg; as_ = s_reg;
                if (op_reg == OP_INC || op_reg == OP_DEC) as_ = 16'h0001;
                if (op_reg == OP_NEG) begin ad = '0; as_ = d_reg; end
                sub_op = op_reg == OP_SUB || op_reg == OP_CMP || op_reg == OP_DEC
                         || op_reg == OP_NEG;
                sum = sub_op ? {1'b0, ad} - {1'b0, as_} : {1'b0, ad} + {1'b0, as_};
                r = sum[W-1:0];
                unique case (op_reg)
                    OP_ADD, OP_SUB, OP_CMP, OP_INC, OP_DEC, OP_NEG: begin
                        lo_next = r;
                        wl_next = op_reg != OP_CMP;
                        if (op_reg != OP_INC && op_reg != OP_DEC) flags_next.cf = sum[W];
                        flags_next.of = sub_op ? ((ad[W-1] ^ as_[W-1]) & (ad[W-1] ^ r[W-1]))
                                        : (~(ad[W-1] ^ as_[W-1]) & (ad[W-1] ^ r[W-1]));
                        flags_next.af = ad[4] ^ as_[4] ^ r[4];
                        flags_next.zf = r == '0; flags_next.sf = r[W-1];
                        flags_next.pf = parity_even(r[7:0]);
                    end
                    OP_AND, OP_OR, OP_XOR: begin
                        r = op_reg == OP_AND ? d_reg & s_reg
                          : op_reg == OP_OR ? d_reg | s_reg : d_reg ^ s_reg;
                        lo_next = r; wl_next = 1'b1;
                        flags_next.cf = 1'b0; flags_next.of = 1'b0; flags_next.af = 1'b0;
                        flags_next.zf = r == '0; flags_next.sf = r[W-1];
                        flags_next.pf = parity_even(r[7:0]);
                    end
                    OP_NOT: begin lo_next = ~d_reg; wl_next = 1'b1; end
                    OP_SHL, OP_SHR: begin
                        r = op_reg == OP_SHL ? {d_reg[W-2:0], 1'b0} : {1'b0, d_reg[W-1:1]};
                        lo_next = r; wl_next = 1'b1;
                        flags_next.cf = op_reg == OP_SHL ? d_reg[W-1] : d_reg[0];
                        flags_next.of = op_reg == OP_SHL ? d_reg[W-1] ^ r[W-1] : d_reg[W-1];
                        flags_next.zf = r == '0; flags_next.sf = r[W-1];
                        flags_next.pf = parity_even(r[7:0]);
                    end
                    OP_MUL, OP_IMUL: begin
                        qneg = op_reg == OP_IMUL && (nneg_reg ^ sneg_reg);
                        prod = qneg ? -iacc : iacc;
                        ov = op_reg == OP_IMUL ? prod[2*W-1:W] != {W{prod[W-1]}}
                                               : prod[2*W-1:W] != '0;
                        lo_next = prod[W-1:0]; hi_next = prod[2*W-1:W];
                        wl_next = 1'b1; wh_next = 1'b1;
                        flags_next.cf = ov; flags_next.of = ov;
                        flags_next.zf = prod == '0; flags_next.sf = prod[2*W-1];
                        flags_next.pf = parity_even(prod[7:0]);
                    end
                    OP_DIV, OP_IDIV: begin
                        qneg = nneg_reg ^ sneg_reg;
                        qm = iacc[W-1:0]; rm = irem[W-1:0];
                        if (s_reg == '0) begin
                            fault_next = FAULT_ZERO;
                        end else if (op_reg == OP_DIV ? h_reg >= s_reg
                                   : (iacc[2*W-1:W] >= ib_mag(s_reg, sneg_reg)
                                      || (qneg ? qm > 16'h8000 : qm[W-1]))) begin
                            fault_next = FAULT_RANGE;
                        end else begin
                            lo_next = qneg ? -qm : qm;
                            hi_next = nneg_reg ? -rm : rm;
                            wl_next = 1'b1; wh_next = 1'b1;
                            flags_next.cf = 1'b0; flags_next.of = 1'b0;
                            flags_next.zf = lo_next == '0; flags_next.sf = lo_next[W-1];
                            flags_next.pf = parity_even(lo_next[7:0]);
                        end
                    end
                    OP_JMP: br_next = 1'b1;
                    OP_JE:  br_next = flags_reg.zf;
                    OP_JNE: br_next = ~flags_reg.zf;
                    OP_JG:  br_next = ~flags_reg.zf & (flags_reg.sf == flags_reg.of);
                    OP_JGE: br_next = flags_reg.sf == flags_reg.of;
                    OP_JL:  br_next = flags_reg.sf != flags_reg.of;
                    OP_JLE: br_next = flags_reg.zf | (flags_reg.sf != flags_reg.of);
                    default: ;
                endcase
            end
            ST_DONE: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {5'd0, flags_reg.pf, flags_reg.af, flags_reg.of, flags_reg.sf,
                      flags_reg.zf, flags_reg.cf, fault_reg, br_reg, wh_reg, wl_reg,
                      hi_reg, lo_reg};

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_fault_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && fault_reg != FAULT_NONE) |-> !wl_reg && !wh_reg)
        else $error("write on fault");
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ITER || state_reg == ST_DONE) |=> $stable(flags_reg) ||
        $past(state_reg) == ST_FIX) else $error("flags changed outside fix-up");
endmodule
`default_nettype wire
